[rtl/assert_macros.svh]
// Assertion macros shared by the half precision logarithm RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define HFL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define HFL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/hfl_pkg.sv]
// Shared types, constants and functions of the half precision logarithm.
// Holds the coefficient table builder and the binary16 arithmetic helpers; no dependencies.
`default_nettype none

package hfl_pkg;

  localparam int unsigned SegmentsDefault = 8;
  localparam int unsigned MidDepth        = 4;
  localparam int unsigned OutDepth        = 16;
  localparam int unsigned FracCount       = 1024;

  localparam logic [15:0] HalfOne  = 16'h3c00;
  localparam logic [15:0] HalfTwo  = 16'h4000;
  localparam logic [15:0] HalfNan  = 16'h7e00;
  localparam logic [14:0] HalfInf  = 15'h7c00;
  localparam logic [4:0]  ExpBias  = 5'h0f;
  localparam logic [4:0]  ExpMag8  = 5'h12;
  localparam logic [4:0]  ExpMag4  = 5'h11;
  localparam logic [4:0]  ExpMag2  = 5'h10;
  localparam real         Ln2Real  = 0.6931471805599453;

  typedef enum logic {
    OpMul,
    OpAdd
  } fop_e;

  // Exact intermediate: value is mag * 2^expo unless spec is set.
  typedef struct packed {
    logic               spec;
    logic [15:0]        spec_val;
    logic               sign;
    logic [41:0]        mag;
    logic signed [6:0]  expo;
  } exact_t;

  // Work item handed from the front to the back.
  typedef struct packed {
    logic [15:0] m;
    logic [15:0] k;
    logic [15:0] b;
    logic [15:0] e;
  } item_t;

  typedef logic [FracCount-1:0][31:0] coef_rom_t;

  // ---------------------------------------------------------------- elaboration helpers
  function automatic real pow2i(int e);
    real r;
    int  n;
    r = 1.0;
    n = e;
    while (n > 0) begin
      r = r * 2.0;
      n = n - 1;
    end
    while (n < 0) begin
      r = r * 0.5;
      n = n + 1;
    end
    return r;
  endfunction

  function automatic int round_even(real v);
    int  f;
    real r;
    f = $rtoi(v);
    r = v - real'(f);
    if (r > 0.5 || (r == 0.5 && f[0])) begin
      f = f + 1;
    end
    return f;
  endfunction

  function automatic logic [15:0] to_half(real d);
    logic [63:0] raw;
    logic [15:0] s;
    real         a;
    int          e;
    int          r;
    raw = $realtobits(d);
    s   = raw[63] ? 16'h8000 : 16'h0000;
    a   = (d < 0.0) ? -d : d;
    if (a >= 65520.0) begin
      return s | {1'b0, HalfInf};
    end
    if (a < pow2i(-14)) begin
      return s | 16'(round_even(a * pow2i(24)));
    end
    e = 15;
    while (e > -14 && a < pow2i(e)) begin
      e = e - 1;
    end
    r = ((e + 15) << 10) + round_even(a * pow2i(10 - e)) - 1024;
    return s | 16'(r);
  endfunction

  // Reciprocal of a positive value: scale into [1,2) by powers of two, then Newton steps.
  function automatic real recip_pos(real v);
    real s;
    real y;
    real r;
    s = 1.0;
    while (v * s >= 2.0) begin
      s = s * 0.5;
    end
    while (v * s < 1.0) begin
      s = s * 2.0;
    end
    y = v * s;
    r = 1.5 - 0.5 * y;
    for (int i = 0; i < 8; i++) begin
      r = r * (2.0 - y * r);
    end
    return r * s;
  endfunction

  // Quotient by a positive divisor, with one correction step on the residual.
  function automatic real quot_pos(real a, real b);
    real r;
    real q;
    r = recip_pos(b);
    q = a * r;
    return q + (a - q * b) * r;
  endfunction

  // log2 on about [1,2] through the atanh series.
  function automatic real log2_series(real x);
    real z;
    real z2;
    real term;
    real sum;
    z    = quot_pos(x - 1.0, x + 1.0);
    z2   = z * z;
    term = z;
    sum  = 0.0;
    for (int i = 0; i < 60; i++) begin
      sum  = sum + quot_pos(term, real'(2 * i + 1));
      term = term * z2;
    end
    return 2.0 * sum / Ln2Real;
  endfunction

  // Table of {k, b} for every fraction value; overlapping pieces are ORed.
  function automatic coef_rom_t build_coef_rom(int unsigned segs);
    coef_rom_t   rom;
    real         x1;
    real         x2;
    real         k;
    real         b1;
    real         b2;
    real         xt;
    logic [15:0] hx1;
    logic [15:0] hx2;
    logic [31:0] kb;
    int          lo;
    int          hi;
    rom = '0;
    for (int i = 0; i < int'(segs); i++) begin
      x1  = quot_pos(real'(i), real'(segs)) + 1.0;
      x2  = quot_pos(real'(i) + 1.0, real'(segs)) + 1.0;
      k   = quot_pos(log2_series(x2) - log2_series(x1), x2 - x1);
      b1  = log2_series(x1) - k * x1;
      xt  = quot_pos(1.0 / Ln2Real, k);
      b2  = log2_series(xt) - k * xt;
      hx1 = to_half(x1);
      hx2 = to_half(x2);
      kb  = {to_half(k), to_half((b1 + b2) / 2.0)};
      lo  = (int'(hx1) < int'(HalfOne)) ? int'(HalfOne) : int'(hx1);
      hi  = (int'(hx2) > int'(HalfTwo)) ? int'(HalfTwo) : int'(hx2);
      for (int v = lo; v < hi; v++) begin
        rom[v - int'(HalfOne)] = rom[v - int'(HalfOne)] | kb;
      end
    end
    return rom;
  endfunction

  localparam logic [15:0] Ln2Half = to_half(Ln2Real);

  // ---------------------------------------------------------------- datapath helpers
  function automatic logic [15:0] exp_code(logic [4:0] ef);
    logic       neg;
    logic [4:0] mag;
    logic [4:0] ee;
    logic [9:0] em;
    if (ef == ExpBias) begin
      return 16'h0000;
    end
    neg = ~ef[4];
    mag = neg ? (ExpBias - ef) : (ef - ExpBias);
    priority if (mag[3]) begin
      ee = ExpMag8;
      em = {mag[2:0], 7'b0};
    end else if (mag[2]) begin
      ee = ExpMag4;
      em = {mag[1:0], 8'b0};
    end else if (mag[1]) begin
      ee = ExpMag2;
      em = {mag[0], 9'b0};
    end else begin
      ee = ExpBias;
      em = '0;
    end
    return {neg, ee, em};
  endfunction

  function automatic logic is_nan(logic [15:0] h);
    return (h[14:10] == 5'h1f) && (h[9:0] != '0);
  endfunction

  function automatic logic is_inf(logic [15:0] h);
    return h[14:0] == HalfInf;
  endfunction

  function automatic logic is_zero(logic [15:0] h);
    return h[14:0] == '0;
  endfunction

  function automatic int exp_eff(logic [15:0] h);
    return (h[14:10] == '0) ? 1 : int'(h[14:10]);
  endfunction

  function automatic exact_t fmul_exact(logic [15:0] a, logic [15:0] b);
    exact_t      r;
    logic [10:0] ma;
    logic [10:0] mb;
    r      = '0;
    r.sign = a[15] ^ b[15];
    ma     = {a[14:10] != '0, a[9:0]};
    mb     = {b[14:10] != '0, b[9:0]};
    if (is_nan(a) || is_nan(b)) begin
      r.spec     = 1'b1;
      r.spec_val = HalfNan;
    end else if (is_inf(a) || is_inf(b)) begin
      r.spec     = 1'b1;
      r.spec_val = (is_zero(a) || is_zero(b)) ? HalfNan : {r.sign, HalfInf};
    end else begin
      r.mag  = 42'({11'b0, ma} * {11'b0, mb});
      r.expo = 7'(exp_eff(a) + exp_eff(b) - 50);
    end
    return r;
  endfunction

  function automatic exact_t fadd_exact(logic [15:0] a, logic [15:0] b);
    exact_t      r;
    int          ea;
    int          eb;
    int          emin;
    logic [41:0] aa;
    logic [41:0] bb;
    r    = '0;
    ea   = exp_eff(a);
    eb   = exp_eff(b);
    emin = (ea < eb) ? ea : eb;
    aa   = 42'({a[14:10] != '0, a[9:0]}) << (ea - emin);
    bb   = 42'({b[14:10] != '0, b[9:0]}) << (eb - emin);
    if (is_nan(a) || is_nan(b)) begin
      r.spec     = 1'b1;
      r.spec_val = HalfNan;
    end else if (is_inf(a) && is_inf(b)) begin
      r.spec     = 1'b1;
      r.spec_val = (a[15] != b[15]) ? HalfNan : a;
    end else if (is_inf(a)) begin
      r.spec     = 1'b1;
      r.spec_val = a;
    end else if (is_inf(b)) begin
      r.spec     = 1'b1;
      r.spec_val = b;
    end else begin
      r.expo = 7'(emin - 25);
      if (a[15] == b[15]) begin
        r.sign = a[15];
        r.mag  = aa + bb;
      end else if (aa > bb) begin
        r.sign = a[15];
        r.mag  = aa - bb;
      end else if (bb > aa) begin
        r.sign = b[15];
        r.mag  = bb - aa;
      end else begin
        r.sign = 1'b0;
        r.mag  = '0;
      end
    end
    return r;
  endfunction

  function automatic logic [5:0] find_lead(logic [41:0] mag);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 42; i++) begin
      if (mag[i]) begin
        p = 6'(i);
      end
    end
    return p;
  endfunction

  // Round an exact value to binary16, nearest even, with overflow to infinity.
  function automatic logic [15:0] round_pack(exact_t x, logic [5:0] lead);
    int          pe;
    int          q;
    int          s;
    int          r;
    int          pat;
    logic [41:0] kept;
    logic [41:0] gbit;
    logic [41:0] low;
    logic        sticky;
    if (x.spec) begin
      return x.spec_val;
    end
    if (x.mag == '0) begin
      return {x.sign, 15'h0000};
    end
    pe = int'(lead) + int'(x.expo);
    q  = (pe - 10 > -24) ? (pe - 10) : -24;
    s  = q - int'(x.expo);
    if (s <= 0) begin
      kept = x.mag << (-s);
      r    = int'(kept[11:0]);
    end else begin
      kept   = x.mag >> s;
      gbit   = x.mag >> (s - 1);
      low    = x.mag & ((42'd1 << (s - 1)) - 42'd1);
      sticky = low != '0;
      r      = int'(kept[11:0]) + ((gbit[0] && (sticky || kept[0])) ? 1 : 0);
    end
    pat = ((q + 25) << 10) + r - 1024;
    if (q + 25 >= 31 || pat >= int'(HalfInf)) begin
      pat = int'(HalfInf);
    end
    return {x.sign, 15'(pat)};
  endfunction

endpackage

`default_nettype wire

[rtl/half_float_natural_log.sv]
// Natural logarithm of a binary16 operand, returned as binary16, with queue style ports.
// Depends on hfl_pkg, hfl_front, hfl_fifo and hfl_back.
//
// The block takes one operand per clock while full is low and, once the pipeline has
// filled, delivers one result per clock as long as results are popped. An operand
// transfer happens on a clock edge with push high and full low; the oldest result sits
// on ln_bits_o while empty is low and is removed by a transfer with pop high. The front
// end registers the operand together with the segment coefficients read from a constant
// table indexed by the ten fraction bits, and with the exponent recoded as a binary16
// value; it then hands the item over a four entry queue. The back end runs four binary16
// units in a chain (multiply by the slope, add the offset, add the exponent, multiply by
// ln 2), each of them pipelined. Issue into the back end is governed by credits against
// the sixteen entry result queue: items keep flowing as long as results are taken, and a
// stalled consumer backs the queues up until full is raised. The sign bit is ignored;
// zero, subnormal, infinite and NaN operands go through the same arithmetic with the
// usual binary16 special value rules in each unit.
// The Segments parameter sets how many linear pieces cover the mantissa range.
`default_nettype none

module half_float_natural_log import hfl_pkg::*; #(
  parameter int unsigned Segments = SegmentsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [15:0] x_bits_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [15:0]      ln_bits_o
);

  item_t front_item;
  logic  front_valid;
  logic  mid_full;
  logic  mid_empty;
  logic  mid_pop;
  item_t mid_item;

  hfl_front #(.Segments(Segments)) u_front (
    .clk_i, .rst_ni,
    .push_i(push), .full_o(full), .x_bits_i,
    .item_valid_o(front_valid), .item_ready_i(~mid_full), .item_o(front_item)
  );

  // Decouples the coefficient lookup from the arithmetic chain.
  hfl_fifo #(.Width($bits(item_t)), .Depth(MidDepth)) u_mid_q (
    .clk_i, .rst_ni,
    .push_i(front_valid), .full_o(mid_full), .data_i(front_item),
    .pop_i(mid_pop), .empty_o(mid_empty), .data_o(mid_item)
  );

  hfl_back u_back (
    .clk_i, .rst_ni,
    .item_i(mid_item), .item_empty_i(mid_empty), .item_pop_o(mid_pop),
    .empty_o(empty), .pop_i(pop), .ln_bits_o
  );

endmodule

`default_nettype wire

[rtl/hfl_fifo.sv]
// Small first-in first-out queue built from registers.
// Generic in width and depth; no package dependencies.
`default_nettype none

module hfl_fifo #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  output logic                  full_o,
  input  wire logic [Width-1:0] data_i,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output logic [Width-1:0]      data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/hfl_front.sv]
// Front end: takes operands, splits them into mantissa and exponent code, reads coefficients.
// Depends on hfl_pkg for the coefficient table builder and the exponent coding.
`default_nettype none

module hfl_front import hfl_pkg::*; #(
  parameter int unsigned Segments = SegmentsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  output logic             full_o,
  input  wire logic [15:0] x_bits_i,
  output logic             item_valid_o,
  input  wire logic        item_ready_i,
  output item_t            item_o
);

  localparam coef_rom_t CoefRom = build_coef_rom(Segments);

  logic        valid_q;
  logic        accept;
  logic [9:0]  frac_q;
  logic [31:0] coef_q;
  logic [15:0] ecode_q;

  // The holding register frees up in the same cycle that its item moves on.
  assign full_o       = valid_q & ~item_ready_i;
  assign accept       = push_i & ~full_o;
  assign item_valid_o = valid_q;

  assign item_o.m = HalfOne | {6'b0, frac_q};
  assign item_o.k = coef_q[31:16];
  assign item_o.b = coef_q[15:0];
  assign item_o.e = ecode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (item_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      frac_q  <= x_bits_i[9:0];
      coef_q  <= CoefRom[x_bits_i[9:0]];
      ecode_q <= exp_code(x_bits_i[14:10]);
    end
  end

endmodule

`default_nettype wire

[rtl/hfl_fpu.sv]
// Three stage binary16 multiply or add with round to nearest even.
// Depends on hfl_pkg for the exact arithmetic, leading one search and rounding.
`default_nettype none

module hfl_fpu import hfl_pkg::*; #(
  parameter fop_e Op = OpMul
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  wire logic [15:0] a_i,
  input  wire logic [15:0] b_i,
  output logic             valid_o,
  output logic [15:0]      res_o
);

  logic [2:0]  valid_q;
  exact_t      exact_d;
  exact_t      xa_q;
  exact_t      xb_q;
  logic [5:0]  lead_q;
  logic [15:0] res_q;

  // Stage one forms the exact result, stage two finds its leading one, stage three rounds.
  always_comb begin
    if (Op == OpMul) begin
      exact_d = fmul_exact(a_i, b_i);
    end else begin
      exact_d = fadd_exact(a_i, b_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    xa_q   <= exact_d;
    xb_q   <= xa_q;
    lead_q <= find_lead(xa_q.mag);
    res_q  <= round_pack(xb_q, lead_q);
  end

  assign valid_o = valid_q[2];
  assign res_o   = res_q;

endmodule

`default_nettype wire

[rtl/hfl_back.sv]
// Back end: four chained binary16 units and the result queue, with credit based issue.
// Depends on hfl_pkg, hfl_fpu, hfl_fifo and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module hfl_back import hfl_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  item_t            item_i,
  input  wire logic        item_empty_i,
  output logic             item_pop_o,
  output logic             empty_o,
  input  wire logic        pop_i,
  output logic [15:0]      ln_bits_o
);

  localparam int unsigned CntW = $clog2(OutDepth + 1);

  logic            issue;
  logic            pop_acc;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [15:0]     b_dly_q [3];
  logic [15:0]     e_dly_q [6];
  logic            v1, v2, v3, v4;
  logic [15:0]     r1, r2, r3, r4;
  logic            out_full;

  // The count covers items in flight and items queued, so the queue can never overflow.
  assign issue      = ~item_empty_i & (cnt_q < CntW'(OutDepth));
  assign item_pop_o = issue;
  assign pop_acc    = pop_i & ~empty_o;

  always_comb begin
    cnt_d = cnt_q;
    if (issue && !pop_acc) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_acc && !issue) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_dly_q[0] <= item_i.b;
    b_dly_q[1] <= b_dly_q[0];
    b_dly_q[2] <= b_dly_q[1];
    e_dly_q[0] <= item_i.e;
    for (int i = 1; i < 6; i++) begin
      e_dly_q[i] <= e_dly_q[i-1];
    end
  end

  hfl_fpu #(.Op(OpMul)) u_mul_k (
    .clk_i, .rst_ni, .valid_i(issue), .a_i(item_i.m), .b_i(item_i.k),
    .valid_o(v1), .res_o(r1)
  );

  hfl_fpu #(.Op(OpAdd)) u_add_b (
    .clk_i, .rst_ni, .valid_i(v1), .a_i(r1), .b_i(b_dly_q[2]),
    .valid_o(v2), .res_o(r2)
  );

  hfl_fpu #(.Op(OpAdd)) u_add_e (
    .clk_i, .rst_ni, .valid_i(v2), .a_i(r2), .b_i(e_dly_q[5]),
    .valid_o(v3), .res_o(r3)
  );

  hfl_fpu #(.Op(OpMul)) u_mul_ln (
    .clk_i, .rst_ni, .valid_i(v3), .a_i(r3), .b_i(Ln2Half),
    .valid_o(v4), .res_o(r4)
  );

  hfl_fifo #(.Width(16), .Depth(OutDepth)) u_out_q (
    .clk_i, .rst_ni,
    .push_i(v4), .full_o(out_full), .data_i(r4),
    .pop_i, .empty_o, .data_o(ln_bits_o)
  );

  `HFL_ASSERT(a_credit_bound, cnt_q <= CntW'(OutDepth), "credit count above queue depth")
  `HFL_ASSERT(a_no_overflow, v4 |-> !out_full, "result arrived at a full queue")
  `HFL_ASSERT(a_queued_counted, !empty_o |-> cnt_q != '0, "queued result not counted")
  `HFL_ASSERT_NEXT(a_credit_return, pop_acc && !issue, cnt_q == $past(cnt_q) - 1'b1,
                   "credit not returned on transfer")

endmodule

`default_nettype wire

[sim/tb_half_float_natural_log.sv]
// Self-checking testbench for half_float_natural_log: a directed table and a random stream
// are checked against a binary16 logarithm predictor. Depends on the RTL and on hfl_pkg.
module tb_half_float_natural_log;

  localparam int Segs      = hfl_pkg::SegmentsDefault;
  localparam int RandItems = 750;
  localparam int DrainWait = 40;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [15:0] x_bits_i;
  logic        empty;
  logic        pop;
  logic [15:0] ln_bits_o;

  half_float_natural_log dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .x_bits_i (x_bits_i),
    .empty    (empty),
    .pop      (pop),
    .ln_bits_o(ln_bits_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // ------------------------------------------------------------------ binary16 predictor
  // Every product and sum of two binary16 values is exact in a double, so each unit is
  // modelled by exact real arithmetic followed by one round to nearest even.
  logic [15:0] seg_lo [Segs];
  logic [15:0] seg_hi [Segs];
  logic [15:0] seg_slope [Segs];
  logic [15:0] seg_offset [Segs];
  logic [15:0] ln2_half;

  function automatic real two_to(int e);
    real r;
    r = 1.0;
    for (int i = 0; i < e; i++) r = r * 2.0;
    for (int i = 0; i > e; i--) r = r * 0.5;
    return r;
  endfunction

  function automatic int nearest_even(real v);
    int  f;
    real frac;
    f    = $rtoi(v);
    frac = v - real'(f);
    if (frac > 0.5 || (frac == 0.5 && f[0])) f = f + 1;
    return f;
  endfunction

  function automatic logic [15:0] real_to_fp16(real d);
    logic [63:0] raw;
    logic [15:0] sgn;
    real         a;
    int          e;
    raw = $realtobits(d);
    sgn = raw[63] ? 16'h8000 : 16'h0000;
    a   = (d < 0.0) ? -d : d;
    if (a >= 65520.0) return sgn | 16'h7c00;
    if (a < two_to(-14)) return sgn | 16'(nearest_even(a * two_to(24)));
    e = 15;
    while (e > -14 && a < two_to(e)) e = e - 1;
    return sgn | 16'(((e + 15) << 10) + nearest_even(a * two_to(10 - e)) - 1024);
  endfunction

  function automatic real fp16_to_real(logic [15:0] h);
    real v;
    if (h[14:10] == 5'd0) v = real'(h[9:0]) * two_to(-24);
    else v = real'({1'b1, h[9:0]}) * two_to(int'(h[14:10]) - 25);
    return h[15] ? -v : v;
  endfunction

  function automatic logic fp16_nan(logic [15:0] h);
    return h[14:10] == 5'h1f && h[9:0] != 10'd0;
  endfunction

  function automatic logic fp16_inf(logic [15:0] h);
    return h[14:0] == 15'h7c00;
  endfunction

  function automatic logic [15:0] fp16_mul(logic [15:0] a, logic [15:0] b);
    if (fp16_nan(a) || fp16_nan(b)) return 16'h7e00;
    if (fp16_inf(a) || fp16_inf(b)) begin
      if (a[14:0] == 15'd0 || b[14:0] == 15'd0) return 16'h7e00;
      return {a[15] ^ b[15], 15'h7c00};
    end
    return real_to_fp16(fp16_to_real(a) * fp16_to_real(b));
  endfunction

  function automatic logic [15:0] fp16_add(logic [15:0] a, logic [15:0] b);
    if (fp16_nan(a) || fp16_nan(b)) return 16'h7e00;
    if (fp16_inf(a) && fp16_inf(b)) return (a[15] != b[15]) ? 16'h7e00 : a;
    if (fp16_inf(a)) return a;
    if (fp16_inf(b)) return b;
    return real_to_fp16(fp16_to_real(a) + fp16_to_real(b));
  endfunction

  // log2 on roughly [1,2] from the atanh series.
  function automatic real log2_near_one(real x);
    real z;
    real z2;
    real term;
    real acc;
    z    = (x - 1.0) / (x + 1.0);
    z2   = z * z;
    term = z;
    acc  = 0.0;
    for (int i = 0; i < 60; i++) begin
      acc  = acc + term / real'(2 * i + 1);
      term = term * z2;
    end
    return 2.0 * acc / 0.6931471805599453;
  endfunction

  // The unbiased exponent recoded as a half value; only bits 3 to 0 of its magnitude
  // survive, so an all-ones exponent field comes out as plus one.
  function automatic logic [15:0] exp_as_half(logic [4:0] ef);
    logic       neg;
    logic [4:0] mag;
    logic [4:0] ee;
    logic [9:0] em;
    if (ef == 5'h0f) return 16'h0000;
    neg = ~ef[4];
    mag = neg ? 5'h0f - ef : ef - 5'h0f;
    if (mag[3]) begin
      ee = 5'h12;
      em = {mag[2:0], 7'd0};
    end else if (mag[2]) begin
      ee = 5'h11;
      em = {mag[1:0], 8'd0};
    end else if (mag[1]) begin
      ee = 5'h10;
      em = {mag[0], 9'd0};
    end else begin
      ee = 5'h0f;
      em = 10'd0;
    end
    return {neg, ee, em};
  endfunction

  function automatic logic [15:0] ln_of_half(logic [15:0] x);
    logic [15:0] m;
    logic [15:0] slope;
    logic [15:0] offset;
    logic [15:0] acc;
    m      = {6'b001111, x[9:0]};
    slope  = 16'd0;
    offset = 16'd0;
    for (int i = 0; i < Segs; i++) begin
      if (seg_lo[i] <= m && m < seg_hi[i]) begin
        slope  = slope | seg_slope[i];
        offset = offset | seg_offset[i];
      end
    end
    acc = fp16_mul(m, slope);
    acc = fp16_add(acc, offset);
    acc = fp16_add(acc, exp_as_half(x[14:10]));
    return fp16_mul(acc, ln2_half);
  endfunction

  initial begin
    real x1;
    real x2;
    real k;
    real xt;
    real b_chord;
    real b_tan;
    for (int i = 0; i < Segs; i++) begin
      x1            = real'(i) / real'(Segs) + 1.0;
      x2            = real'(i + 1) / real'(Segs) + 1.0;
      k             = (log2_near_one(x2) - log2_near_one(x1)) / (x2 - x1);
      b_chord       = log2_near_one(x1) - k * x1;
      xt            = 1.0 / 0.6931471805599453 / k;
      b_tan         = log2_near_one(xt) - k * xt;
      seg_lo[i]     = real_to_fp16(x1);
      seg_hi[i]     = real_to_fp16(x2);
      seg_slope[i]  = real_to_fp16(k);
      seg_offset[i] = real_to_fp16((b_chord + b_tan) / 2.0);
    end
    ln2_half = real_to_fp16(0.6931471805599453);
  end

  // ------------------------------------------------------------------ stimulus
  // Directed operands: zeros of both signs, subnormals, one, the largest finite value,
  // infinities, NaNs, every exponent coding branch and the segment boundaries at 1.125, 1.25, 1.5 and 1.875.
  localparam logic [15:0] DirectedOps [25] = '{
    16'h0000, 16'h8000, 16'h0001, 16'h03ff, 16'h3c00, 16'hbc00, 16'h7bff, 16'h7c00,
    16'hfc00, 16'h7c01, 16'h7e00, 16'h7fff, 16'hffff, 16'h3fff, 16'h4000, 16'h4400,
    16'h3800, 16'h3400, 16'h5000, 16'h2000, 16'h3c80, 16'h3d00, 16'h3e00, 16'h3f80,
    16'h0400
  };

  logic [15:0] operands [$];
  logic [15:0] ln_expected_q [$];
  int          sent;
  int          burst_left;
  int          gap_left;
  int          cycle;
  bit          failed;

  initial begin
    foreach (DirectedOps[i]) operands.push_back(DirectedOps[i]);
    for (int i = 0; i < RandItems; i++) operands.push_back(16'($urandom));
  end

  // Sender: bursts of random length separated by random gaps. A held operand stays on
  // the port until its transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push       <= 1'b0;
      x_bits_i   <= 16'd0;
      sent       = 0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (push && !full) begin
        ln_expected_q.push_back(ln_of_half(x_bits_i));
        sent = sent + 1;
      end
      if (!(push && full)) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          push <= 1'b0;
        end else if (sent < operands.size()) begin
          burst_left = burst_left - 1;
          push     <= 1'b1;
          x_bits_i <= operands[sent];
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each transfer out, then stalls according to the cycle count so that
  // free-flowing stretches alternate with sparse and random popping.
  always @(posedge clk_i or negedge rst_ni) begin
    logic [15:0] want;
    if (!rst_ni) begin
      pop   <= 1'b0;
      cycle = 0;
    end else begin
      cycle = cycle + 1;
      if (pop && !empty) begin
        if (ln_expected_q.size() == 0) begin
          $display("%0t: result 0x%04h with nothing outstanding", $realtime, ln_bits_o);
          failed = 1'b1;
        end else begin
          want = ln_expected_q.pop_front();
          if (ln_bits_o !== want) begin
            $display("%0t: ln_bits expected 0x%04h actual 0x%04h", $realtime, want, ln_bits_o);
            failed = 1'b1;
          end
        end
      end
      case (cycle[8:7])
        2'd0: pop <= 1'b1;
        2'd1: pop <= ($urandom_range(0, 3) != 0);
        2'd2: pop <= (cycle % 5 == 0);
        default: pop <= ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  initial begin
    failed = 1'b0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (operands.size() > 0 && sent == operands.size());
    wait (ln_expected_q.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
    if (!failed && ln_expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2400000;
    $display("Mismatches found");
    $finish;
  end

endmodule
